@@ rtl/core/hcbp_pkg.sv @@
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

    localparam int CODE_BITS = 32;
    localparam int LEN_BITS  = 6;
    localparam int ACC_BITS  = 64;
    localparam int OUT_BITS  = 32;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [LEN_BITS-1:0]  len;
    } entry_t;

    // Control of the item held in the lookup stage
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       in_range;
    } stage_t;

endpackage

@@ rtl/core/huffman_code_bit_packer_unit.sv @@
// Huffman code bit packer: code table lookup and LSB-first word packing.
//
// Input channel s_*: s_tuser carries the opcode (load, encode, flush),
// s_tdata the symbol, code bits and code length. A load writes the code
// table entry of the symbol; an encode appends that entry's code above the
// pending bits; a flush emits the pending partial word with m_tlast high.
// Output channel m_*: one packed word per transfer, earliest bit at bit 0.
// A word reaches m_tvalid through the lookup stage and the table read
// register, both loaded at the accept edge of the item that completes it,
// and then through the accumulator update and the output register.
// Throughput: one item per cycle while s_tready is high, set by one table
// access per item and the combinational shift-or of the accumulator.
// A load followed at once by an encode of the same symbol reads the new
// entry, as the write lands at the load's accept edge.
// Reset clears the accumulator, the pending count and both valid flags;
// the table holds nothing defined until loaded.
// When m_tready is low with a word waiting, s_tready drops only while the
// lookup stage is also occupied; the stages and the word hold until taken.
module huffman_code_bit_packer_unit
    import hcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int WORD_BITS    = 32,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,    // symbol[7:0], code_bits[39:8], code_length[45:40]
    input  logic [1:0]          s_tuser,    // opcode[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata,    // packed_word[31:0]
    output logic                m_tlast     // is_final
);

    localparam int AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LIM = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam logic [LEN_BITS-1:0] LEN_LIM   = LEN_BITS'(LIM);
    localparam logic [8:0]          SYM_LIMIT = 9'(SYMBOL_COUNT);

    logic [7:0]           symbol;
    logic [CODE_BITS-1:0] code_bits;
    logic [LEN_BITS-1:0]  code_length;
    logic [LEN_BITS-1:0]  len_sat;
    logic                 in_range;
    logic                 accept;
    logic                 advance;
    entry_t               wr_entry;
    entry_t               rd_entry;
    stage_t               stage_reg, stage_next;

    assign symbol      = s_tdata[7:0];
    assign code_bits   = s_tdata[39:8];
    assign code_length = s_tdata[45:40];

    assign in_range = ({1'b0, symbol} < SYM_LIMIT);
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    // saturate the length and drop code bits above it
    assign len_sat        = (code_length > LEN_LIM) ? LEN_LIM : code_length;
    assign wr_entry.len   = len_sat;
    assign wr_entry.code  = code_bits & ~({CODE_BITS{1'b1}} << len_sat);

    always_comb
    begin
        stage_next = stage_reg;
        if (advance)
        begin
            stage_next.valid    = accept;
            stage_next.op       = s_tuser;
            stage_next.in_range = in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    hcbp_code_table #(
        .DEPTH (SYMBOL_COUNT),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (accept && (s_tuser == OP_LOAD) && in_range),
        .wr_addr (symbol[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (accept && (s_tuser == OP_ENCODE)),
        .rd_addr (symbol[AW-1:0]),
        .rd_data (rd_entry)
    );

    hcbp_packer #(
        .WORD_BITS (WORD_BITS)
    ) u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage_reg),
        .entry    (rd_entry),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/core/hcbp_code_table.sv @@
// Code table memory: one write and one read per cycle, registered read data.
module hcbp_code_table
    import hcbp_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/hcbp_packer.sv @@
// Bit accumulator, word emission and output register.
module hcbp_packer
    import hcbp_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  stage_t              stage,
    input  entry_t              entry,
    output logic                advance,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata,    // packed_word[31:0]
    output logic                m_tlast     // is_final
);

    localparam logic [OUT_BITS-1:0] WORD_MASK = {OUT_BITS{1'b1}} >> (OUT_BITS - WORD_BITS);
    localparam logic [LEN_BITS-1:0] WORD_LEN  = LEN_BITS'(WORD_BITS);

    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic [LEN_BITS-1:0] pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_word_reg, out_word_next;
    logic                out_last_reg, out_last_next;

    logic [ACC_BITS-1:0] merged;
    logic [LEN_BITS-1:0] sum;
    logic                do_enc;
    logic                emit;
    logic                step;

    assign advance = !stage.valid || !out_valid_reg || m_tready;
    assign step    = stage.valid && advance;

    assign merged = acc_reg | ({{(ACC_BITS-CODE_BITS){1'b0}}, entry.code} << pend_reg);
    assign sum    = pend_reg + entry.len;
    assign do_enc = stage.in_range && (entry.len != '0);

    always_comb
    begin
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        emit          = 1'b0;
        out_word_next = out_word_reg;
        out_last_next = out_last_reg;
        if (step)
        begin
            unique case (stage.op)
                OP_ENCODE:
                begin
                    if (do_enc)
                    begin
                        if (sum >= WORD_LEN)
                        begin
                            emit          = 1'b1;
                            out_word_next = merged[OUT_BITS-1:0] & WORD_MASK;
                            out_last_next = 1'b0;
                            acc_next      = merged >> WORD_BITS;
                            pend_next     = sum - WORD_LEN;
                        end
                        else
                        begin
                            acc_next  = merged;
                            pend_next = sum;
                        end
                    end
                end
                OP_FLUSH:
                begin
                    if (pend_reg != '0)
                    begin
                        emit          = 1'b1;
                        out_word_next = acc_reg[OUT_BITS-1:0] & WORD_MASK;
                        out_last_next = 1'b1;
                        acc_next      = '0;
                        pend_next     = '0;
                    end
                end
                default:
                begin
                    // load and unused codes leave the accumulator alone
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;

endmodule
